// ===== hw/rtl/pvct_pkg.sv =====
// Shared constants and types for the program map table version tracker.
package pvct_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int PID_W = 13;
    localparam int SID_W = 16;
    localparam int VER_W = 5;
    localparam int KEY_W = PID_W + SID_W;
    localparam int WORD_W = KEY_W + VER_W;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Result handed from the scan controller to the output register.
    typedef struct packed {
        logic valid;
        logic changed;
    } pvct_res_t;

endpackage

// ===== hw/rtl/pvct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pvct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/pvct_scan.sv =====
// Scan controller: linear search over the entry RAM, version update, append and clear.
module pvct_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [pvct_pkg::PID_W-1:0]    table_pid,
    input  logic [pvct_pkg::SID_W-1:0]    service_id,
    input  logic [pvct_pkg::VER_W-1:0]    table_version,
    output pvct_pkg::pvct_res_t           res,
    input  logic                          res_take
);
    import pvct_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VER_W-1:0]   ver_reg, ver_next;
    logic               changed_reg, changed_next;

    logic               in_accept;
    logic [KEY_W-1:0]   in_key;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [WORD_W-1:0]  mem_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [VER_W-1:0]   rd_ver;
    logic               hit;
    logic               last;
    logic               full;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_key    = {service_id, table_pid};
    assign rd_key    = mem_rdata[WORD_W-1:VER_W];
    assign rd_ver    = mem_rdata[VER_W-1:0];
    assign hit       = (rd_key == key_reg);
    assign last      = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign full      = (count_reg == CNT_W'(TABLE_ENTRIES));

    assign res.valid   = (state_reg == ST_DONE);
    assign res.changed = changed_reg;

    pvct_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        key_next     = key_reg;
        ver_next     = ver_reg;
        changed_next = changed_reg;
        mem_we       = 1'b0;
        mem_waddr    = count_reg[IDX_W-1:0];
        mem_wdata    = {key_reg, ver_reg};
        // data for idx_reg arrives now; fetch the following entry meanwhile
        mem_raddr    = (state_reg == ST_SCAN) ? IDX_W'(idx_reg + IDX_W'(1)) : '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    key_next = in_key;
                    ver_next = table_version;
                    idx_next = '0;
                    if (operation == OP_CLEAR)
                    begin
                        count_next   = '0;
                        changed_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        mem_we       = 1'b1;
                        mem_waddr    = '0;
                        mem_wdata    = {in_key, table_version};
                        count_next   = CNT_W'(1);
                        changed_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    changed_next = (rd_ver != ver_reg);
                    mem_we       = (rd_ver != ver_reg);
                    mem_waddr    = idx_reg;
                    state_next   = ST_DONE;
                end
                else if (last)
                begin
                    // unknown key: append if there is room, report changed either way
                    changed_next = 1'b1;
                    if (!full)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            changed_reg <= 1'b0;
            key_reg     <= '0;
            ver_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            changed_reg <= changed_next;
            key_reg     <= key_next;
            ver_reg     <= ver_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("scan index past filled entries");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && operation == OP_CLEAR) |=> (count_reg == '0 && !changed_reg))
        else $error("clear did not empty the table");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && $past(state_reg) != ST_IDLE) |->
            (count_reg == $past(count_reg) || count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("entry count moved by more than one");

endmodule

// ===== hw/rtl/pmt_version_change_table_top.sv =====
// Top level of the program map table version tracker: scan controller and result register.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------------
//  input    | in_valid / in_stall | operation, table_pid, service_id, table_version
//  output   | out_valid/out_stall | changed
//
// A check scans the entry RAM one entry per cycle, comparing at most TABLE_ENTRIES
// entries; a clear or a check on an empty table skips the scan.
// Reset empties the table (fill count only; RAM contents are not cleared).
// A new transaction is taken while the last result waits in the output register;
// the controller holds its finished result until that register frees up.
module pmt_version_change_table_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [pvct_pkg::PID_W-1:0]    table_pid,
    input  logic [pvct_pkg::SID_W-1:0]    service_id,
    input  logic [pvct_pkg::VER_W-1:0]    table_version,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          changed
);
    import pvct_pkg::*;

    pvct_res_t  res;
    logic       res_take;
    logic       out_valid_reg, out_valid_next;
    logic       changed_reg, changed_next;

    pvct_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .table_pid     (table_pid),
        .service_id    (service_id),
        .table_version (table_version),
        .res           (res),
        .res_take      (res_take)
    );

    assign res_take = res.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        changed_next   = changed_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            changed_next   = res.changed;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        changed_reg <= changed_next;
    end

    assign out_valid = out_valid_reg;
    assign changed   = changed_reg;

endmodule
